[src/vmt_pkg.sv]
`default_nettype none

package vmt_pkg;

  // Number of coordinate axes handled side by side in every stage
  localparam int unsigned NumAxes = 3;

endpackage

`default_nettype wire

[src/vmt_prep.sv]
`default_nettype none

// Front end: differences, magnitudes, squares, products and the reach test
// in three register stages.
module vmt_prep #(
  parameter int unsigned CW = 32
) (
  input  wire logic                                         clk_i,
  input  wire logic                                         rst_ni,
  input  wire logic                                         valid_i,
  input  wire logic [vmt_pkg::NumAxes-1:0][CW-1:0]          start_i,
  input  wire logic [vmt_pkg::NumAxes-1:0][CW-1:0]          target_i,
  input  wire logic [CW-1:0]                                step_i,
  output logic                                              valid_o,
  output logic [2*CW+1:0]                                   sq_o,
  output logic                                              reached_o,
  output logic [vmt_pkg::NumAxes-1:0][CW-1:0]               base_o,
  output logic [vmt_pkg::NumAxes-1:0][2*CW-1:0]             num_o,
  output logic [vmt_pkg::NumAxes-1:0]                       neg_o
);

  localparam int unsigned NA  = vmt_pkg::NumAxes;
  localparam int unsigned SQW = 2 * CW + 2;

  // Stage A: difference magnitudes and signs
  logic [NA-1:0][CW:0]   a_dmag_d, a_dmag_q;
  logic [NA-1:0]         a_neg_d, a_neg_q;
  logic [CW-1:0]         a_smag_d, a_smag_q;
  logic [NA-1:0][CW-1:0] a_s_q, a_t_q;
  logic                  a_valid_q;

  always_comb begin
    logic [CW:0] diff;
    for (int i = 0; i < NA; i++) begin
      diff        = {target_i[i][CW-1], target_i[i]} - {start_i[i][CW-1], start_i[i]};
      a_dmag_d[i] = diff[CW] ? (CW+1)'(-diff) : diff;
      a_neg_d[i]  = diff[CW] ^ step_i[CW-1];
    end
    a_smag_d = step_i[CW-1] ? CW'(-step_i) : step_i;
  end

  // Stage B: squares and scaled numerators
  logic [NA-1:0][SQW-1:0]  b_sqr_q;
  logic [NA-1:0][2*CW-1:0] b_num_q;
  logic [2*CW-1:0]         b_st_q;
  logic [NA-1:0]           b_neg_q;
  logic [NA-1:0][CW-1:0]   b_s_q, b_t_q;
  logic                    b_valid_q;

  // Stage C: reach decision
  logic [SQW-1:0]          c_sq_d;
  logic                    c_reached_d;

  always_comb begin
    c_sq_d = b_sqr_q[0];
    for (int i = 1; i < NA; i++) begin
      c_sq_d = c_sq_d + b_sqr_q[i];
    end
    c_reached_d = {2'b00, b_st_q} >= c_sq_d;
  end

  // Advance valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
      valid_o   <= 1'b0;
    end else begin
      a_valid_q <= valid_i;
      b_valid_q <= a_valid_q;
      valid_o   <= b_valid_q;
    end
  end

  // Advance payload
  always_ff @(posedge clk_i) begin
    a_dmag_q <= a_dmag_d;
    a_neg_q  <= a_neg_d;
    a_smag_q <= a_smag_d;
    a_s_q    <= start_i;
    a_t_q    <= target_i;
    for (int i = 0; i < NA; i++) begin
      b_sqr_q[i] <= {{(CW+1){1'b0}}, a_dmag_q[i]} * {{(CW+1){1'b0}}, a_dmag_q[i]};
      b_num_q[i] <= {{(CW-1){1'b0}}, a_dmag_q[i]} * {{CW{1'b0}}, a_smag_q};
    end
    b_st_q    <= {{CW{1'b0}}, a_smag_q} * {{CW{1'b0}}, a_smag_q};
    b_neg_q   <= a_neg_q;
    b_s_q     <= a_s_q;
    b_t_q     <= a_t_q;
    sq_o      <= c_sq_d;
    reached_o <= c_reached_d;
    base_o    <= c_reached_d ? b_t_q : b_s_q;
    num_o     <= b_num_q;
    neg_o     <= b_neg_q;
  end

endmodule

`default_nettype wire

[src/vmt_sqrt.sv]
`default_nettype none

// Integer square root, one root bit per register stage.
module vmt_sqrt #(
  parameter int unsigned RW   = 33,
  parameter int unsigned PAYW = 8
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            valid_i,
  input  wire logic [2*RW-1:0] rad_i,
  input  wire logic [PAYW-1:0] pay_i,
  output logic                 valid_o,
  output logic [RW-1:0]        root_o,
  output logic [PAYW-1:0]      pay_o
);

  logic            vld_q  [RW+1];
  logic [2*RW-1:0] rem_q  [RW+1];
  logic [RW-1:0]   root_q [RW+1];
  logic [PAYW-1:0] pay_q  [RW+1];

  assign vld_q[0]  = valid_i;
  assign rem_q[0]  = rad_i;
  assign root_q[0] = '0;
  assign pay_q[0]  = pay_i;

  for (genvar k = 0; k < RW; k++) begin : g_stage
    localparam int unsigned B = RW - 1 - k;
    logic [2*RW-1:0] inc;
    logic            take;

    // Trial increment (2r + 2^b) * 2^b for setting root bit b
    assign inc  = (({{(RW-1){1'b0}}, root_q[k], 1'b0}) | ((2*RW)'(1) << B)) << B;
    assign take = rem_q[k] >= inc;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k+1] <= 1'b0;
      end else begin
        vld_q[k+1] <= vld_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      rem_q[k+1]  <= take ? rem_q[k] - inc : rem_q[k];
      root_q[k+1] <= take ? (root_q[k] | (RW'(1) << B)) : root_q[k];
      pay_q[k+1]  <= pay_q[k];
    end
  end

  assign valid_o = vld_q[RW];
  assign root_o  = root_q[RW];
  assign pay_o   = pay_q[RW];

  a_sqrt_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> $past(valid_i, RW))
    else $error("sqrt output valid without matching input");

endmodule

`default_nettype wire

[src/vmt_div.sv]
`default_nettype none

// Restoring divider for all axes, one quotient bit per register stage.
module vmt_div #(
  parameter int unsigned CW   = 32,
  parameter int unsigned PAYW = 8
) (
  input  wire logic                                    clk_i,
  input  wire logic                                    rst_ni,
  input  wire logic                                    valid_i,
  input  wire logic [vmt_pkg::NumAxes-1:0][2*CW-1:0]   num_i,
  input  wire logic [CW:0]                             den_i,
  input  wire logic [PAYW-1:0]                         pay_i,
  output logic                                         valid_o,
  output logic [vmt_pkg::NumAxes-1:0][CW-1:0]          quo_o,
  output logic [PAYW-1:0]                              pay_o
);

  localparam int unsigned NA = vmt_pkg::NumAxes;

  logic                        vld_q [CW+1];
  logic [NA-1:0][CW+1:0]       rem_q [CW+1];
  logic [NA-1:0][CW-1:0]       low_q [CW+1];
  logic [CW:0]                 den_q [CW+1];
  logic [PAYW-1:0]             pay_q [CW+1];

  // Load the upper half as the partial remainder
  for (genvar i = 0; i < NA; i++) begin : g_load
    assign rem_q[0][i] = {2'b00, num_i[i][2*CW-1:CW]};
    assign low_q[0][i] = num_i[i][CW-1:0];
  end
  assign vld_q[0] = valid_i;
  assign den_q[0] = den_i;
  assign pay_q[0] = pay_i;

  for (genvar k = 0; k < CW; k++) begin : g_stage
    logic [NA-1:0][CW+1:0] rem_d;
    logic [NA-1:0][CW-1:0] low_d;

    // Shift in one numerator bit, subtract if it fits
    always_comb begin
      logic [CW+1:0] sh;
      logic          ge;
      for (int i = 0; i < NA; i++) begin
        sh       = {rem_q[k][i][CW:0], low_q[k][i][CW-1]};
        ge       = sh >= {1'b0, den_q[k]};
        rem_d[i] = ge ? sh - {1'b0, den_q[k]} : sh;
        low_d[i] = {low_q[k][i][CW-2:0], ge};
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k+1] <= 1'b0;
      end else begin
        vld_q[k+1] <= vld_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      rem_q[k+1] <= rem_d;
      low_q[k+1] <= low_d;
      den_q[k+1] <= den_q[k];
      pay_q[k+1] <= pay_q[k];
    end
  end

  assign valid_o = vld_q[CW];
  assign quo_o   = low_q[CW];
  assign pay_o   = pay_q[CW];

  a_div_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> $past(valid_i, CW))
    else $error("divider output valid without matching input");

endmodule

`default_nettype wire

[src/vector3_move_towards_core.sv]
`default_nettype none

// Move a 3D point toward a target by a step distance.
//
// Input: a transaction is taken on a rising edge with start_i high and
// busy_o low. busy_o stays low: the pipeline takes one transaction per
// cycle, back to back, with no gaps required.
// Output: each result appears on result_*_o and reached_o for exactly one
// cycle, marked by done_o. Results leave in input order.
// The path runs through three front-end stages, the square root
// (COORD_WIDTH+1 stages, one root bit each), the divider (COORD_WIDTH
// stages, one quotient bit each) and one output stage.
// Throughput: one transaction per cycle.
// Reset clears all valid bits; transactions in flight are dropped.
// The receiver cannot stall; the result must be taken in its done_o cycle.
module vector3_move_towards_core #(
  parameter int unsigned COORD_WIDTH = 32
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start_i,
  output logic                               busy_o,
  input  wire logic signed [COORD_WIDTH-1:0] start_x_i,
  input  wire logic signed [COORD_WIDTH-1:0] start_y_i,
  input  wire logic signed [COORD_WIDTH-1:0] start_z_i,
  input  wire logic signed [COORD_WIDTH-1:0] target_x_i,
  input  wire logic signed [COORD_WIDTH-1:0] target_y_i,
  input  wire logic signed [COORD_WIDTH-1:0] target_z_i,
  input  wire logic signed [COORD_WIDTH-1:0] step_distance_i,
  output logic                               done_o,
  output logic signed [COORD_WIDTH-1:0]      result_x_o,
  output logic signed [COORD_WIDTH-1:0]      result_y_o,
  output logic signed [COORD_WIDTH-1:0]      result_z_o,
  output logic                               reached_o
);

  localparam int unsigned CW      = COORD_WIDTH;
  localparam int unsigned NA      = vmt_pkg::NumAxes;
  localparam int unsigned DPAYW   = NA * CW + NA + 1;
  localparam int unsigned SPAYW   = DPAYW + NA * 2 * CW;
  localparam int unsigned Latency = 2 * CW + 5;

  assign busy_o = 1'b0;

  // Front end
  logic                     p_valid, p_reached;
  logic [2*CW+1:0]          p_sq;
  logic [NA-1:0][CW-1:0]    p_base;
  logic [NA-1:0][2*CW-1:0]  p_num;
  logic [NA-1:0]            p_neg;

  vmt_prep #(.CW(CW)) u_prep (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (start_i & ~busy_o),
    .start_i   ({start_z_i, start_y_i, start_x_i}),
    .target_i  ({target_z_i, target_y_i, target_x_i}),
    .step_i    (step_distance_i),
    .valid_o   (p_valid),
    .sq_o      (p_sq),
    .reached_o (p_reached),
    .base_o    (p_base),
    .num_o     (p_num),
    .neg_o     (p_neg)
  );

  // Length of the difference vector
  logic                     s_valid;
  logic [CW:0]              s_len;
  logic [SPAYW-1:0]         s_pay;
  logic [NA-1:0][2*CW-1:0]  s_num;
  logic [DPAYW-1:0]         s_dpay;

  vmt_sqrt #(.RW(CW + 1), .PAYW(SPAYW)) u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (p_valid),
    .rad_i   (p_sq),
    .pay_i   ({p_num, p_base, p_neg, p_reached}),
    .valid_o (s_valid),
    .root_o  (s_len),
    .pay_o   (s_pay)
  );

  assign s_num  = s_pay[SPAYW-1:DPAYW];
  assign s_dpay = s_pay[DPAYW-1:0];

  // Scaled step per axis
  logic                  d_valid;
  logic [NA-1:0][CW-1:0] d_quo;
  logic [DPAYW-1:0]      d_pay;
  logic [NA-1:0][CW-1:0] d_base;
  logic [NA-1:0]         d_neg;
  logic                  d_reached;

  vmt_div #(.CW(CW), .PAYW(DPAYW)) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s_valid),
    .num_i   (s_num),
    .den_i   (s_len),
    .pay_i   (s_dpay),
    .valid_o (d_valid),
    .quo_o   (d_quo),
    .pay_o   (d_pay)
  );

  assign d_base    = d_pay[DPAYW-1:NA+1];
  assign d_neg     = d_pay[NA:1];
  assign d_reached = d_pay[0];

  // Add the signed step and saturate
  logic [NA-1:0][CW-1:0] res_d, res_q;
  logic                  done_q, reached_q;

  always_comb begin
    logic [CW+1:0] q;
    logic [CW+1:0] b;
    logic [CW+1:0] sum;
    for (int i = 0; i < NA; i++) begin
      q   = d_reached ? '0 : {2'b00, d_quo[i]};
      b   = {{2{d_base[i][CW-1]}}, d_base[i]};
      sum = d_neg[i] ? b - q : b + q;
      if (sum[CW+1:CW-1] == '0 || sum[CW+1:CW-1] == '1) begin
        res_d[i] = sum[CW-1:0];
      end else begin
        res_d[i] = {sum[CW+1], {(CW-1){~sum[CW+1]}}};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= d_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q     <= res_d;
    reached_q <= d_reached;
  end

  assign done_o     = done_q;
  assign result_x_o = res_q[0];
  assign result_y_o = res_q[1];
  assign result_z_o = res_q[2];
  assign reached_o  = reached_q;

  a_fixed_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |-> ##Latency done_o)
    else $error("transaction did not complete at the fixed latency");

endmodule

`default_nettype wire

[sim/tb_vector3_move_towards_core.sv]
`timescale 1ns / 1ps

module tb_vector3_move_towards_core;

  localparam int unsigned CW = 32;
  localparam int unsigned LATENCY = 2 * CW + 5;
  localparam int unsigned NUM_RANDOM = 1630;
  localparam longint unsigned CYCLE_LIMIT = 400000;

  typedef logic signed [CW-1:0] coord_t;

  typedef struct packed {
    coord_t sx, sy, sz, tx, ty, tz, step;
  } move_req_t;

  typedef struct packed {
    coord_t rx, ry, rz;
    logic   reached;
  } move_res_t;

  typedef struct {
    move_req_t req;
    logic      has_golden;
    move_res_t golden;
  } dir_row_t;

  logic   clk_i, rst_ni, start_i;
  logic   busy_o, done_o, reached_o;
  coord_t start_x_i, start_y_i, start_z_i;
  coord_t target_x_i, target_y_i, target_z_i, step_distance_i;
  coord_t result_x_o, result_y_o, result_z_o;

  move_res_t       pending_moves[$];
  dir_row_t        dir_rows[$];
  int unsigned     mismatch_count;
  int unsigned     result_count;
  int unsigned     reached_count;
  int unsigned     sat_count;
  longint unsigned cycle_count;
  logic            idle_enable;

  vector3_move_towards_core #(.COORD_WIDTH(CW)) DUT (
    .clk_i, .rst_ni, .start_i, .busy_o,
    .start_x_i, .start_y_i, .start_z_i,
    .target_x_i, .target_y_i, .target_z_i, .step_distance_i,
    .done_o, .result_x_o, .result_y_o, .result_z_o, .reached_o
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Floor square root of a 128-bit value, one root bit at a time
  function automatic logic [63:0] floor_root(logic [127:0] n);
    logic [63:0] root;
    logic [63:0] trial;
    root = '0;
    for (int b = 63; b >= 0; b--) begin
      trial = root | (64'd1 << b);
      if ({64'd0, trial} * {64'd0, trial} <= n) root = trial;
    end
    return root;
  endfunction

  // Compute the moved point for one request
  function automatic move_res_t move_point(move_req_t r);
    move_res_t res;
    logic signed [63:0] s[3], t[3], d[3];
    logic [63:0] dm[3];
    logic [127:0] dist_sq, step_sq, q;
    logic [63:0] step_mag, len;
    logic signed [127:0] sum;
    logic neg;
    s = '{64'(r.sx), 64'(r.sy), 64'(r.sz)};
    t = '{64'(r.tx), 64'(r.ty), 64'(r.tz)};
    dist_sq = '0;
    for (int i = 0; i < 3; i++) begin
      d[i] = t[i] - s[i];
      dm[i] = d[i][63] ? -d[i] : d[i];
      dist_sq += {64'd0, dm[i]} * {64'd0, dm[i]};
    end
    step_mag = r.step[CW-1] ? -64'(r.step) : 64'(r.step);
    step_sq = {64'd0, step_mag} * {64'd0, step_mag};
    if (step_sq >= dist_sq) begin
      res = '{rx: r.tx, ry: r.ty, rz: r.tz, reached: 1'b1};
      return res;
    end
    len = floor_root(dist_sq);
    for (int i = 0; i < 3; i++) begin
      q = ({64'd0, dm[i]} * {64'd0, step_mag}) / {64'd0, len};
      neg = (d[i][63] ^ r.step[CW-1]) && (q != 0);
      sum = 128'(s[i]) + (neg ? -$signed(q) : $signed(q));
      if (sum > 128'sh7FFF_FFFF) sum = 128'sh7FFF_FFFF;
      else if (sum < -128'sh8000_0000) sum = -128'sh8000_0000;
      case (i)
        0: res.rx = sum[CW-1:0];
        1: res.ry = sum[CW-1:0];
        default: res.rz = sum[CW-1:0];
      endcase
    end
    res.reached = 1'b0;
    return res;
  endfunction

  function automatic coord_t rand_coord();
    case ($urandom_range(0, 5))
      0: return coord_t'($urandom);
      1: return coord_t'($urandom_range(0, 8) == 0 ? 32'h8000_0000 : 32'h7FFF_FFFF);
      2: return coord_t'($signed($urandom_range(0, 2000)) - 1000);
      3: return coord_t'($signed($urandom_range(0, 32'h0040_0000)) - 32'sh0020_0000);
      default: return coord_t'($signed($urandom_range(0, 32'h2000_0000)) - 32'sh1000_0000);
    endcase
  endfunction

  // Random request: mostly short steps toward far targets, some reach and noise
  function automatic move_req_t rand_request();
    move_req_t r;
    logic [31:0] span;
    r.sx = rand_coord(); r.sy = rand_coord(); r.sz = rand_coord();
    case ($urandom_range(0, 9))
      0: begin
        r.tx = r.sx; r.ty = r.sy; r.tz = r.sz;
        r.step = coord_t'($urandom);
      end
      1, 2: begin
        r.tx = rand_coord(); r.ty = rand_coord(); r.tz = rand_coord();
        r.step = coord_t'($urandom);
      end
      default: begin
        r.tx = rand_coord(); r.ty = rand_coord(); r.tz = rand_coord();
        span = 32'd1 << $urandom_range(0, 31);
        r.step = coord_t'($urandom_range(0, span - 1));
        if ($urandom_range(0, 3) == 0) r.step = -r.step;
      end
    endcase
    return r;
  endfunction

  // Present one transaction, with an optional idle burst before it
  task automatic send_move(move_req_t r);
    if (idle_enable && $urandom_range(0, 3) == 0) begin
      start_i <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk_i);
    end
    start_i <= 1'b1;
    {start_x_i, start_y_i, start_z_i} <= {r.sx, r.sy, r.sz};
    {target_x_i, target_y_i, target_z_i} <= {r.tx, r.ty, r.tz};
    step_distance_i <= r.step;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    pending_moves.push_back(move_point(r));
  endtask

  function automatic void add_row(move_req_t r, logic has_golden, move_res_t g);
    dir_row_t row;
    row.req = r;
    row.has_golden = has_golden;
    row.golden = g;
    dir_rows.push_back(row);
  endfunction

  // Check results as they leave
  always @(posedge clk_i) begin
    move_res_t got, want;
    if (rst_ni && done_o) begin
      got = '{rx: result_x_o, ry: result_y_o, rz: result_z_o, reached: reached_o};
      result_count++;
      if (reached_o) reached_count++;
      if (!reached_o && (result_x_o == 32'h7FFF_FFFF || result_x_o == 32'h8000_0000))
        sat_count++;
      if (pending_moves.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) $display("unexpected result %p", got);
      end else begin
        want = pending_moves.pop_front();
        if (got.rx !== want.rx || got.ry !== want.ry || got.rz !== want.rz
            || got.reached !== want.reached) begin
          mismatch_count++;
          if (mismatch_count <= 10) $display("mismatch: expected %p, actual %p", want, got);
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("FAIL vector3_move_towards_core");
      $finish;
    end
  end

  initial begin
    move_req_t r;
    move_res_t g;
    int unsigned wait_cycles;
    coord_t vmax, vmin;
    vmax = 32'sh7FFF_FFFF;
    vmin = 32'sh8000_0000;
    mismatch_count = 0; result_count = 0; reached_count = 0; sat_count = 0;
    cycle_count = 0;
    idle_enable = 1'b1;
    rst_ni = 1'b0; start_i = 1'b0;
    {start_x_i, start_y_i, start_z_i} = '0;
    {target_x_i, target_y_i, target_z_i} = '0;
    step_distance_i = '0;

    // Start on target: target back, reached, for any step
    r = '{sx: vmax, sy: vmin, sz: 0, tx: vmax, ty: vmin, tz: 0, step: 0};
    add_row(r, 1'b1, '{rx: vmax, ry: vmin, rz: 0, reached: 1'b1});
    r.step = vmin;
    add_row(r, 1'b1, '{rx: vmax, ry: vmin, rz: 0, reached: 1'b1});
    // Step well beyond the gap
    r = '{sx: 0, sy: 0, sz: 0, tx: 32'sh10000, ty: 0, tz: 0, step: vmax};
    add_row(r, 1'b1, '{rx: 32'sh10000, ry: 0, rz: 0, reached: 1'b1});
    // Exact reach on an axis
    r = '{sx: 0, sy: 0, sz: 0, tx: 0, ty: 0, tz: 32'sh30000, step: 32'sh30000};
    add_row(r, 1'b1, '{rx: 0, ry: 0, rz: 32'sh30000, reached: 1'b1});
    // Half step along an axis
    r = '{sx: 0, sy: 0, sz: 0, tx: 32'sh40000, ty: 0, tz: 0, step: 32'sh20000};
    add_row(r, 1'b1, '{rx: 32'sh20000, ry: 0, rz: 0, reached: 1'b0});
    // Zero step, not reached: stay put
    r = '{sx: 5, sy: -7, sz: 9, tx: 100, ty: 0, tz: 0, step: 0};
    add_row(r, 1'b1, '{rx: 5, ry: -7, rz: 9, reached: 1'b0});
    // Negative steps push away from the target and saturate
    r = '{sx: vmin, sy: vmax, sz: 0, tx: vmax, ty: vmin, tz: 0, step: vmin + 1};
    add_row(r, 1'b0, g);
    r = '{sx: vmax, sy: vmin, sz: vmin, tx: vmin, ty: vmax, tz: vmax, step: -32'sd1000};
    add_row(r, 1'b0, g);
    r = '{sx: vmax - 10, sy: 0, sz: 0, tx: 0, ty: 0, tz: 0, step: -32'sh10000};
    add_row(r, 1'b1, '{rx: vmax, ry: 0, rz: 0, reached: 1'b0});
    // Corner to corner, long diagonals, then a short and a bit-pattern diagonal
    r = '{sx: vmin, sy: vmin, sz: vmin, tx: vmax, ty: vmax, tz: vmax, step: vmax};
    add_row(r, 1'b0, g);
    r = '{sx: vmax, sy: vmax, sz: vmax, tx: vmin, ty: vmin, tz: vmin, step: 1};
    add_row(r, 1'b0, g);
    r = '{sx: -1, sy: -1, sz: -1, tx: 2, ty: 3, tz: -5, step: 3};
    add_row(r, 1'b0, g);
    r = '{sx: 32'sh5555_5555, sy: 32'shAAAA_AAAA, sz: 32'sh0F0F_0F0F,
          tx: 32'shAAAA_AAAA, ty: 32'sh5555_5555, tz: 32'shF0F0_F0F0, step: 32'sh1234_5678};
    add_row(r, 1'b0, g);

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed table
    foreach (dir_rows[i]) begin
      send_move(dir_rows[i].req);
      if (dir_rows[i].has_golden && move_point(dir_rows[i].req) !== dir_rows[i].golden) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("table row %0d: expected %p, predicted %p", i, dir_rows[i].golden,
                   move_point(dir_rows[i].req));
      end
    end

    // Random transactions; the last stretch runs back to back
    for (int n = 0; n < NUM_RANDOM; n++) begin
      if (n == NUM_RANDOM - 300) idle_enable = 1'b0;
      send_move(rand_request());
    end
    start_i <= 1'b0;

    // Drain
    wait_cycles = 0;
    while (pending_moves.size() != 0 && wait_cycles < 20 * LATENCY) begin
      @(posedge clk_i);
      wait_cycles++;
    end
    repeat (LATENCY + 5) @(posedge clk_i);

    $display("%0d results checked, %0d reached, %0d saturated on x", result_count,
             reached_count, sat_count);
    $display("mismatches: %0d, left over: %0d", mismatch_count, pending_moves.size());
    if (mismatch_count == 0 && pending_moves.size() == 0) begin
      $display("PASS vector3_move_towards_core");
    end else begin
      $display("FAIL vector3_move_towards_core");
    end
    $finish;
  end

endmodule
